FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/vrs_pkg.sv
// Shared types and constants of the vibration RMS/std accumulator.
// No dependencies; vrs_if, vrs_dp, vrs_ctrl, the top level and the checker refer to it.
`default_nettype none

package vrs_pkg;

  localparam int RAW_W      = 16;
  localparam int VAL_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RAD_W      = 48;
  localparam int MAX_PACKET_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_STATS_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_AXES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16   = 3'd5;

  localparam logic [15:0] RST_DECIMATION = 16'd1;
  localparam logic [12:0] RST_PACKET_LEN = 13'd4096;
  localparam logic [15:0] RST_SCALE_Q16  = 16'd7995;

  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_BAD = 2'd3;
  localparam logic [1:0] TAG_ALL  = 2'd3;

  localparam logic signed [VAL_W-1:0] STAT_MAX = 24'sh7FFFFF;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_RMS    = 2'd1,
    KIND_STD    = 2'd2
  } kind_t;

  typedef struct packed {
    logic       accept;
    logic       scale;
    logic       count;
    logic       acc;
    logic       mul1;
    logic       mul2;
    logic       calc_var;
    logic       div_go;
    logic       div_std;
    logic       sqrt_go;
    logic       store_rms;
    logic       store_std;
    logic       load_out;
    logic       clear_sums;
    kind_t      out_kind;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic keep_now;
    logic stats_mode;
    logic close;
    logic out_free;
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/vrs_if.sv
// Request channels of the block: raw samples in, results out, register writes.
// Depends on vrs_pkg for field widths and the result kind type.
`default_nettype none

interface vrs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vrs_pkg::RAW_W-1:0]    raw_x;
  logic signed [vrs_pkg::RAW_W-1:0]    raw_y;
  logic signed [vrs_pkg::RAW_W-1:0]    raw_z;
  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface vrs_out_if;
  logic                                valid;
  logic                                ready;
  vrs_pkg::kind_t                      kind;
  logic signed [vrs_pkg::VAL_W-1:0]    value_x;
  logic signed [vrs_pkg::VAL_W-1:0]    value_y;
  logic signed [vrs_pkg::VAL_W-1:0]    value_z;
  logic [1:0]                          axis_tag;
  logic                                last;
  modport source (output valid, kind, value_x, value_y, value_z, axis_tag, last,
                  input ready);
  modport sink (input valid, kind, value_x, value_y, value_z, axis_tag, last,
                output ready);
endinterface

interface vrs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [vrs_pkg::CFG_IDX_W-1:0]       index;
  logic [vrs_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/vibration_rms_std_accumulator_top.sv
// Top level of the decimated vibration RMS / standard deviation accumulator.
// Depends on vrs_pkg, vrs_if, vrs_ctrl and vrs_dp.
//
// Usage:
//   in_if  : one raw x/y/z accelerometer sample per request.
//   out_if : result requests (scaled sample, or RMS followed by std per packet).
//   cfg_if : register writes by index; always ready, write only while idle.
// A dropped sample (decimation) is accepted in S_IDLE and leaves the block idle.
// A kept sample passes S_SCALE and S_MG; in sample mode S_EMIT_S then loads it
// into the result register once that is free, and in statistics mode S_ACC adds
// it to the sums. The sample that closes a statistics packet then runs a serial
// divider (one quotient bit per cycle, NUM_W = 72 numerator bits and a 26-bit
// denominator at the default packet limit) and a serial square root (24 root
// bits, one per cycle) twice per axis, before the RMS and std requests are offered.
// Reset clears the counters and sums and loads the register defaults.
// A stalled receiver holds the result register; the block takes no new
// sample until the pending result has been loaded into it.
`default_nettype none

module vibration_rms_std_accumulator_top #(
  parameter int MAX_PACKET = vrs_pkg::MAX_PACKET_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vrs_in_if.sink     in_if,
  vrs_out_if.source  out_if,
  vrs_cfg_if.sink    cfg_if
);

  vrs_pkg::cmd_t cmd;
  vrs_pkg::sts_t sts;

  assign cfg_if.ready = 1'b1;

  vrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrs_dp #(.MaxPacket(MAX_PACKET)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .raw_x        (in_if.raw_x),
    .raw_y        (in_if.raw_y),
    .raw_z        (in_if.raw_z),
    .cfg_valid    (cfg_if.valid),
    .cfg_index    (cfg_if.index),
    .cfg_data     (cfg_if.data),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_kind     (out_if.kind),
    .out_value_x  (out_if.value_x),
    .out_value_y  (out_if.value_y),
    .out_value_z  (out_if.value_z),
    .out_axis_tag (out_if.axis_tag),
    .out_last     (out_if.last)
  );

endmodule

`default_nettype wire

FILE: rtl/core/vrs_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone unit; used by vrs_dp for the statistics quotients.
`default_nettype none

module vrs_div #(
  parameter int NUM_W = 72,
  parameter int DEN_W = 26
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/vrs_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone unit; used by vrs_dp after each statistics division.
`default_nettype none

module vrs_isqrt #(
  parameter int IN_W = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [IN_W-1:0]   rad,
  output logic                   done,
  output logic [IN_W/2-1:0]      root
);

  localparam int ROOT_W = IN_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [IN_W-1:0]   rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r, rad_r[IN_W-1 -: 2]};
    trial  = (ROOT_W + 4)'({root_r, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[IN_W-3:0], 2'b00};
      rem_r  <= ge ? (ROOT_W + 2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: rtl/core/vrs_dp.sv
// Datapath: registers, decimation and packet counters, scaling, sums,
// statistics arithmetic and the result register. Uses vrs_pkg, vrs_div, vrs_isqrt.
`default_nettype none

module vrs_dp #(
  parameter int MaxPacket = vrs_pkg::MAX_PACKET_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire vrs_pkg::cmd_t                       cmd,
  output vrs_pkg::sts_t                            sts,
  input  wire logic signed [vrs_pkg::RAW_W-1:0]    raw_x,
  input  wire logic signed [vrs_pkg::RAW_W-1:0]    raw_y,
  input  wire logic signed [vrs_pkg::RAW_W-1:0]    raw_z,
  input  wire logic                                cfg_valid,
  input  wire logic [vrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vrs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output vrs_pkg::kind_t                           out_kind,
  output logic signed [vrs_pkg::VAL_W-1:0]         out_value_x,
  output logic signed [vrs_pkg::VAL_W-1:0]         out_value_y,
  output logic signed [vrs_pkg::VAL_W-1:0]         out_value_z,
  output logic [1:0]                               out_axis_tag,
  output logic                                     out_last
);

  localparam int L     = $clog2(MaxPacket);
  localparam int CNT_W = L + 1;
  localparam int SUM_W = 16 + L;
  localparam int SQ_W  = 31 + L;
  localparam int NQ_W  = SQ_W + CNT_W;
  localparam int NN_W  = 2 * CNT_W;
  localparam int NUM_W = NQ_W + 16;
  localparam int LO_W  = SQ_W / 2;
  localparam int VW    = vrs_pkg::VAL_W;
  localparam logic [31:0] MAX32 = 32'(MaxPacket);

  // Configuration registers.
  logic        stats_mode_r;
  logic        all_axes_r;
  logic [1:0]  axis_select_r;
  logic [15:0] decimation_r;
  logic [12:0] packet_len_r;
  logic [15:0] scale_r;

  logic [15:0]             decim_count_r;
  logic [CNT_W-1:0]        sample_count_r;
  logic [CNT_W-1:0]        n_r;
  logic                    close_r;
  logic signed [15:0]      raw_r [3];
  logic signed [32:0]      prod_r [3];
  logic signed [15:0]      mg_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  logic [SQ_W-1:0]         sq_r [3];
  logic [NQ_W-1:0]         nq_lo_r;
  logic [NQ_W-1:0]         nq_r;
  logic [2*SUM_W-1:0]      s2_r;
  logic [NN_W-1:0]         nn_r;
  logic [NQ_W-1:0]         vari_r;
  logic signed [VW-1:0]    rms_r [3];
  logic signed [VW-1:0]    sd_r [3];
  logic                    out_valid_r;
  vrs_pkg::kind_t          out_kind_r;
  logic signed [VW-1:0]    out_x_r;
  logic signed [VW-1:0]    out_y_r;
  logic signed [VW-1:0]    out_z_r;
  logic [1:0]              out_tag_r;
  logic                    out_last_r;

  logic [15:0]             dec_eff;
  logic [15:0]             decim_inc;
  logic                    keep_now;
  logic [12:0]             plen_raw;
  logic [31:0]             plen_eff;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    close_now;
  logic [1:0]              sel;
  logic signed [15:0]      mg_nxt [3];
  logic signed [31:0]      sqr [3];
  logic [SQ_W-1:0]         q_sel;
  logic signed [SUM_W-1:0] s_sel;
  logic [SUM_W-1:0]        s_abs;
  logic [NQ_W-1:0]         nq_hi;
  logic [NUM_W-1:0]        div_num;
  logic [NN_W-1:0]         div_den;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;
  logic                    sqrt_done;
  logic [vrs_pkg::RAD_W/2-1:0] root;
  logic signed [VW-1:0]    root_sat;
  logic signed [VW-1:0]    vs [3];

  function automatic logic signed [15:0] sat_mg(input logic signed [32:0] p);
    logic [32:0]        mag;
    logic [16:0]        q;
    logic signed [17:0] s;
    mag = p[32] ? 33'(-p) : 33'(p);
    q   = mag[32:16];
    s   = p[32] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (s > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (s < -18'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  always_comb begin
    dec_eff   = (decimation_r == 16'd0) ? 16'd1 : decimation_r;
    decim_inc = decim_count_r + 16'd1;
    keep_now  = !(decim_inc < dec_eff);
    plen_raw  = (packet_len_r == 13'd0) ? 13'd1 : packet_len_r;
    plen_eff  = (32'(plen_raw) > MAX32) ? MAX32 : 32'(plen_raw);
    cnt_inc   = sample_count_r + 1'b1;
    close_now = 32'(cnt_inc) >= plen_eff;
    sel       = (axis_select_r == vrs_pkg::AXIS_BAD) ? vrs_pkg::AXIS_Z : axis_select_r;
    for (int a = 0; a < 3; a++) begin
      mg_nxt[a] = sat_mg(prod_r[a]);
      sqr[a]    = mg_r[a] * mg_r[a];
    end
    q_sel   = sq_r[cmd.axis];
    s_sel   = sum_r[cmd.axis];
    s_abs   = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
    nq_hi   = n_r * q_sel[SQ_W-1:LO_W];
    div_num = cmd.div_std ? {vari_r, 16'h0000} : NUM_W'({q_sel, 16'h0000});
    div_den = cmd.div_std ? nn_r : NN_W'(n_r);
    root_sat = root[VW-1] ? vrs_pkg::STAT_MAX : VW'(root);
  end

  vrs_div #(.NUM_W(NUM_W), .DEN_W(NN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Both quotients stay below 2^47, so the low bits carry the whole value.
  vrs_isqrt #(.IN_W(vrs_pkg::RAD_W)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.sqrt_go),
    .rad   (div_quo[vrs_pkg::RAD_W-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_mode_r   <= 1'b0;
      all_axes_r     <= 1'b1;
      axis_select_r  <= vrs_pkg::AXIS_X;
      decimation_r   <= vrs_pkg::RST_DECIMATION;
      packet_len_r   <= vrs_pkg::RST_PACKET_LEN;
      scale_r        <= vrs_pkg::RST_SCALE_Q16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vrs_pkg::REG_STATS_MODE:  stats_mode_r  <= cfg_data[0];
        vrs_pkg::REG_ALL_AXES:    all_axes_r    <= cfg_data[0];
        vrs_pkg::REG_AXIS_SELECT: axis_select_r <= cfg_data[1:0];
        vrs_pkg::REG_DECIMATION:  decimation_r  <= cfg_data;
        vrs_pkg::REG_PACKET_LEN:  packet_len_r  <= cfg_data[12:0];
        vrs_pkg::REG_SCALE_Q16:   scale_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_count_r  <= '0;
      sample_count_r <= '0;
      close_r        <= 1'b0;
    end else begin
      if (cmd.accept) begin
        decim_count_r <= keep_now ? 16'd0 : decim_inc;
      end
      if (cmd.count) begin
        sample_count_r <= close_now ? '0 : cnt_inc;
        close_r        <= close_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= '0;
        sq_r[a]  <= '0;
      end
    end else if (cmd.clear_sums || (cmd.count && close_now && !stats_mode_r)) begin
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= '0;
        sq_r[a]  <= '0;
      end
    end else if (cmd.acc) begin
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= sum_r[a] + SUM_W'(mg_r[a]);
        sq_r[a]  <= sq_r[a] + SQ_W'($unsigned(sqr[a]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      raw_r[0] <= raw_x;
      raw_r[1] <= raw_y;
      raw_r[2] <= raw_z;
    end
    for (int a = 0; a < 3; a++) begin
      if (cmd.scale) begin
        prod_r[a] <= $signed(raw_r[a]) * $signed({1'b0, scale_r});
      end
      if (cmd.count) begin
        mg_r[a] <= mg_nxt[a];
      end
    end
    if (cmd.count) begin
      n_r <= cnt_inc;
    end
    if (cmd.mul1) begin
      nq_lo_r <= n_r * q_sel[LO_W-1:0];
      s2_r    <= s_abs * s_abs;
      nn_r    <= n_r * n_r;
    end
    if (cmd.mul2) begin
      nq_r <= nq_lo_r + (nq_hi << LO_W);
    end
    if (cmd.calc_var) begin
      vari_r <= (nq_r > NQ_W'(s2_r)) ? nq_r - NQ_W'(s2_r) : '0;
    end
    if (cmd.store_rms) begin
      rms_r[cmd.axis] <= root_sat;
    end
    if (cmd.store_std) begin
      sd_r[cmd.axis] <= root_sat;
    end
  end

  // Result register.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (cmd.out_kind)
        vrs_pkg::KIND_SAMPLE: vs[a] = VW'(mg_r[a]);
        vrs_pkg::KIND_RMS:    vs[a] = rms_r[a];
        vrs_pkg::KIND_STD:    vs[a] = sd_r[a];
        default:              vs[a] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind_r <= cmd.out_kind;
      out_x_r    <= all_axes_r ? vs[0] : vs[sel];
      out_y_r    <= all_axes_r ? vs[1] : '0;
      out_z_r    <= all_axes_r ? vs[2] : '0;
      out_tag_r  <= all_axes_r ? vrs_pkg::TAG_ALL : sel;
      out_last_r <= (cmd.out_kind == vrs_pkg::KIND_SAMPLE) ? close_r
                                                           : (cmd.out_kind == vrs_pkg::KIND_STD);
    end
  end

  assign sts.keep_now   = keep_now;
  assign sts.stats_mode = stats_mode_r;
  assign sts.close      = close_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.div_done   = div_done;
  assign sts.sqrt_done  = sqrt_done;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_value_x  = out_x_r;
  assign out_value_y  = out_y_r;
  assign out_value_z  = out_z_r;
  assign out_axis_tag = out_tag_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/vrs_ctrl.sv
// Controller: sequences acceptance, scaling, accumulation, statistics and results.
// Depends on vrs_pkg for the command and status structs.
`default_nettype none

module vrs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vrs_pkg::sts_t sts,
  output vrs_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_MG, S_ACC, S_EMIT_S, S_MUL1, S_MUL2, S_VAR,
    S_WDR, S_WSR, S_WDS, S_WSS, S_EMIT_R, S_EMIT_D
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_comb begin
    cmd       = '0;
    cmd.axis  = axis_r;
    state_nxt = state_r;
    axis_nxt  = axis_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.keep_now) state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_MG;
      end
      S_MG: begin
        cmd.count = 1'b1;
        state_nxt = sts.stats_mode ? S_ACC : S_EMIT_S;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.close) begin
          axis_nxt  = vrs_pkg::AXIS_X;
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_S: begin
        cmd.out_kind = vrs_pkg::KIND_SAMPLE;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_VAR;
      end
      S_VAR: begin
        cmd.calc_var = 1'b1;
        cmd.div_go   = 1'b1;
        state_nxt    = S_WDR;
      end
      S_WDR: begin
        if (sts.div_done) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = S_WSR;
        end
      end
      S_WSR: begin
        cmd.div_std = 1'b1;
        if (sts.sqrt_done) begin
          cmd.store_rms = 1'b1;
          cmd.div_go    = 1'b1;
          state_nxt     = S_WDS;
        end
      end
      S_WDS: begin
        if (sts.div_done) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = S_WSS;
        end
      end
      S_WSS: begin
        if (sts.sqrt_done) begin
          cmd.store_std = 1'b1;
          if (axis_r == vrs_pkg::AXIS_Z) begin
            state_nxt = S_EMIT_R;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_MUL1;
          end
        end
      end
      S_EMIT_R: begin
        cmd.out_kind = vrs_pkg::KIND_RMS;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_EMIT_D;
        end
      end
      S_EMIT_D: begin
        cmd.out_kind = vrs_pkg::KIND_STD;
        if (sts.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.clear_sums = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= vrs_pkg::AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vrs_checker.sv
// Port-level checker for the accumulator, bound to the top level.
// Depends on vrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vrs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire vrs_pkg::kind_t                   out_kind,
  input wire logic signed [vrs_pkg::VAL_W-1:0] out_value_y,
  input wire logic signed [vrs_pkg::VAL_W-1:0] out_value_z,
  input wire logic [1:0]                       out_axis_tag,
  input wire logic                             out_last
);

  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_last), "stalled result changed")
  `ASSERT_IMP(a_std_last, out_valid && out_kind == vrs_pkg::KIND_STD, out_last, "std result must close the packet")
  `ASSERT_NXT(a_rms_then_std, out_valid && out_ready && out_kind == vrs_pkg::KIND_RMS, out_valid && out_kind == vrs_pkg::KIND_STD, "RMS result not followed by std")
  `ASSERT_IMP(a_single_zero, out_valid && out_axis_tag != vrs_pkg::TAG_ALL, out_value_y == '0 && out_value_z == '0, "single-axis result carries y or z")

endmodule

bind vibration_rms_std_accumulator_top vrs_checker u_vrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_kind     (out_if.kind),
  .out_value_y  (out_if.value_y),
  .out_value_z  (out_if.value_z),
  .out_axis_tag (out_if.axis_tag),
  .out_last     (out_if.last)
);

`default_nettype wire
